// ----- rtl/bxtri_pkg.sv -----
// Shared types, widths and the triangle corner table for the box triangulator.
`default_nettype none

package bxtri_pkg;

  localparam int CoordW   = 32;  // Q16.16 coordinate
  localparam int LenW     = 31;  // unsigned Q15.16 edge length
  localparam int QuatW    = 16;  // Q1.14 quaternion part
  localparam int ProdW    = 2 * QuatW;   // quaternion product, Q2.28
  localparam int MatW     = ProdW + 1;   // matrix entry, sum of two products
  localparam int TermW    = 64;          // matrix entry times length, Q16.44
  localparam int AccW     = TermW + 2;   // sum of three signed terms
  localparam int FracBits = 28;          // bits dropped when rounding to Q16.16
  localparam int HiW      = AccW - FracBits;
  localparam int SumW     = HiW + 1;     // rounded value plus centre
  localparam int HalfBit  = FracBits - 1;

  localparam logic [5:0] LastVert = 6'd35;
  localparam logic [3:0] LastTri  = 4'd11;
  localparam logic [1:0] LastSlot = 2'd2;

  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< HalfBit;

  // Nine products m[i][j] * len[j] (diagonal carries the half-length too)
  // and the centre; entry n holds row n/3, column n%3.
  typedef struct packed {
    logic [8:0][TermW-1:0]  term;
    logic [2:0][CoordW-1:0] center;
  } box_set_t;

  // Corner code of vertex k: bit0 = +x, bit1 = +y, bit2 = +z.
  function automatic logic [2:0] tri_corner(input logic [5:0] k);
    logic [2:0] c;
    c = 3'd0;
    unique case (k)
      6'd0:  c = 3'd0;  6'd1:  c = 3'd1;  6'd2:  c = 3'd3;
      6'd3:  c = 3'd0;  6'd4:  c = 3'd3;  6'd5:  c = 3'd2;
      6'd6:  c = 3'd0;  6'd7:  c = 3'd1;  6'd8:  c = 3'd5;
      6'd9:  c = 3'd0;  6'd10: c = 3'd5;  6'd11: c = 3'd4;
      6'd12: c = 3'd1;  6'd13: c = 3'd3;  6'd14: c = 3'd7;
      6'd15: c = 3'd1;  6'd16: c = 3'd7;  6'd17: c = 3'd5;
      6'd18: c = 3'd2;  6'd19: c = 3'd3;  6'd20: c = 3'd7;
      6'd21: c = 3'd2;  6'd22: c = 3'd7;  6'd23: c = 3'd6;
      6'd24: c = 3'd0;  6'd25: c = 3'd2;  6'd26: c = 3'd6;
      6'd27: c = 3'd0;  6'd28: c = 3'd6;  6'd29: c = 3'd4;
      6'd30: c = 3'd4;  6'd31: c = 3'd5;  6'd32: c = 3'd7;
      6'd33: c = 3'd4;  6'd34: c = 3'd7;  6'd35: c = 3'd6;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // Apply the corner sign to one term, widened so the sum cannot overflow.
  function automatic logic signed [AccW-1:0] signed_term(input logic [TermW-1:0] t,
                                                         input logic pos);
    logic signed [AccW-1:0] ext;
    ext = AccW'($signed(t));
    return pos ? ext : -ext;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bxtri_setup.sv -----
// Per-box set-up pipeline: quaternion products, rotation matrix, scaled terms.
`default_nettype none

module bxtri_setup (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [bxtri_pkg::CoordW-1:0]   in_center_x,
  input  wire logic signed [bxtri_pkg::CoordW-1:0]   in_center_y,
  input  wire logic signed [bxtri_pkg::CoordW-1:0]   in_center_z,
  input  wire logic        [bxtri_pkg::LenW-1:0]     in_length_x,
  input  wire logic        [bxtri_pkg::LenW-1:0]     in_length_y,
  input  wire logic        [bxtri_pkg::LenW-1:0]     in_length_z,
  input  wire logic signed [bxtri_pkg::QuatW-1:0]    in_quat_w,
  input  wire logic signed [bxtri_pkg::QuatW-1:0]    in_quat_x,
  input  wire logic signed [bxtri_pkg::QuatW-1:0]    in_quat_y,
  input  wire logic signed [bxtri_pkg::QuatW-1:0]    in_quat_z,
  output logic                                       set_valid,
  input  wire logic                                  set_ready,
  output bxtri_pkg::box_set_t                        set_data
);

  localparam int ProdW  = bxtri_pkg::ProdW;
  localparam int MatW   = bxtri_pkg::MatW;
  localparam int TermW  = bxtri_pkg::TermW;
  localparam int LenW   = bxtri_pkg::LenW;
  localparam int CoordW = bxtri_pkg::CoordW;

  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic s1_en, s2_en, s3_en, s4_en;

  // stage 1: quaternion products
  logic signed [ProdW-1:0] s1_xx_r, s1_yy_r, s1_zz_r, s1_xy_r, s1_xz_r;
  logic signed [ProdW-1:0] s1_yz_r, s1_wx_r, s1_wy_r, s1_wz_r;
  logic [2:0][LenW-1:0]    s1_len_r, s2_len_r, s3_len_r;
  logic [2:0][CoordW-1:0]  s1_center_r, s2_center_r, s3_center_r, s4_center_r;

  // stage 2: matrix entries, stage 3: scaled terms, stage 4: diagonal offsets
  logic signed [MatW-1:0]  s2_m_r [9];
  logic [TermW-1:0]        s3_t_r [9];
  logic [TermW-1:0]        s4_t_r [9];

  assign s4_en    = !s4_valid_r || set_ready;
  assign s3_en    = !s3_valid_r || s4_en;
  assign s2_en    = !s2_valid_r || s3_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= in_valid;
      if (s2_en) s2_valid_r <= s1_valid_r;
      if (s3_en) s3_valid_r <= s2_valid_r;
      if (s4_en) s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_xx_r     <= in_quat_x * in_quat_x;
      s1_yy_r     <= in_quat_y * in_quat_y;
      s1_zz_r     <= in_quat_z * in_quat_z;
      s1_xy_r     <= in_quat_x * in_quat_y;
      s1_xz_r     <= in_quat_x * in_quat_z;
      s1_yz_r     <= in_quat_y * in_quat_z;
      s1_wx_r     <= in_quat_w * in_quat_x;
      s1_wy_r     <= in_quat_w * in_quat_y;
      s1_wz_r     <= in_quat_w * in_quat_z;
      s1_len_r    <= {in_length_z, in_length_y, in_length_x};
      s1_center_r <= {in_center_z, in_center_y, in_center_x};
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_m_r[0]   <= -(MatW'(s1_yy_r) + MatW'(s1_zz_r));
      s2_m_r[1]   <= MatW'(s1_xy_r) - MatW'(s1_wz_r);
      s2_m_r[2]   <= MatW'(s1_wy_r) + MatW'(s1_xz_r);
      s2_m_r[3]   <= MatW'(s1_wz_r) + MatW'(s1_xy_r);
      s2_m_r[4]   <= -(MatW'(s1_xx_r) + MatW'(s1_zz_r));
      s2_m_r[5]   <= MatW'(s1_yz_r) - MatW'(s1_wx_r);
      s2_m_r[6]   <= MatW'(s1_xz_r) - MatW'(s1_wy_r);
      s2_m_r[7]   <= MatW'(s1_wx_r) + MatW'(s1_yz_r);
      s2_m_r[8]   <= -(MatW'(s1_xx_r) + MatW'(s1_yy_r));
      s2_len_r    <= s1_len_r;
      s2_center_r <= s1_center_r;
    end
  end

  for (genvar n = 0; n < 9; n++) begin : g_term
    localparam int Row = n / 3;
    localparam int Col = n % 3;
    logic signed [TermW:0]   prod;
    logic        [TermW-1:0] diag;

    assign prod = s2_m_r[n] * $signed({1'b0, s2_len_r[Col]});
    // half-length of the row axis in Q16.44: len * 2^27
    assign diag = (Row == Col)
                ? {{(TermW-LenW-bxtri_pkg::HalfBit){1'b0}}, s3_len_r[Row],
                   {bxtri_pkg::HalfBit{1'b0}}}
                : '0;

    always_ff @(posedge clk) begin
      if (s3_en) s3_t_r[n] <= prod[TermW-1:0];
      if (s4_en) s4_t_r[n] <= s3_t_r[n] + diag;
    end

    assign set_data.term[n] = s4_t_r[n];
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_len_r    <= s2_len_r;
      s3_center_r <= s2_center_r;
    end
    if (s4_en) s4_center_r <= s3_center_r;
  end

  assign set_data.center = s4_center_r;
  assign set_valid       = s4_valid_r;

endmodule

`default_nettype wire

// ----- rtl/bxtri_vertex.sv -----
// Vertex sequencer and per-vertex sum, round, translate and saturate pipeline.
`default_nettype none

module bxtri_vertex (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  set_valid,
  output logic                                       set_ready,
  input  wire bxtri_pkg::box_set_t                   set_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [bxtri_pkg::CoordW-1:0]        out_vertex_x,
  output logic signed [bxtri_pkg::CoordW-1:0]        out_vertex_y,
  output logic signed [bxtri_pkg::CoordW-1:0]        out_vertex_z,
  output logic        [3:0]                          out_triangle_index,
  output logic        [1:0]                          out_corner_slot,
  output logic                                       out_last
);

  localparam int AccW   = bxtri_pkg::AccW;
  localparam int HiW    = bxtri_pkg::HiW;
  localparam int SumW   = bxtri_pkg::SumW;
  localparam int CoordW = bxtri_pkg::CoordW;

  // sequencer
  bxtri_pkg::box_set_t bank_r, bank_nxt;
  logic       busy_r, busy_nxt;
  logic [5:0] k_r, k_nxt;
  logic [3:0] tri_r, tri_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic       issue;
  logic [2:0] code;

  // pipeline
  logic v1_valid_r, v2_valid_r, v3_valid_r;
  logic v1_en, v2_en, v3_en;
  logic signed [AccW-1:0] v1_a_r [3];
  logic signed [AccW-1:0] v1_b_r [3];
  logic signed [HiW-1:0]  v2_hi_r [3];
  logic [CoordW-1:0]      v1_c_r [3];
  logic [CoordW-1:0]      v2_c_r [3];
  logic [CoordW-1:0]      v3_vert_r [3];
  logic [3:0] v1_tri_r, v2_tri_r, v3_tri_r;
  logic [1:0] v1_slot_r, v2_slot_r, v3_slot_r;
  logic       v1_last_r, v2_last_r, v3_last_r;

  assign v3_en = !v3_valid_r || out_ready;
  assign v2_en = !v2_valid_r || v3_en;
  assign v1_en = !v1_valid_r || v2_en;

  assign issue     = busy_r && v1_en;
  assign set_ready = !busy_r || (issue && (k_r == bxtri_pkg::LastVert));
  assign code      = bxtri_pkg::tri_corner(k_r);

  always_comb begin
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    k_nxt    = k_r;
    tri_nxt  = tri_r;
    slot_nxt = slot_r;
    if (issue) begin
      if (k_r == bxtri_pkg::LastVert) begin
        busy_nxt = 1'b0;
        k_nxt    = '0;
        tri_nxt  = '0;
        slot_nxt = '0;
      end else begin
        k_nxt = k_r + 6'd1;
        if (slot_r == bxtri_pkg::LastSlot) begin
          slot_nxt = '0;
          tri_nxt  = tri_r + 4'd1;
        end else begin
          slot_nxt = slot_r + 2'd1;
        end
      end
    end
    // take the next box when idle or as the last vertex of this one leaves
    if (set_valid && set_ready) begin
      bank_nxt = set_data;
      busy_nxt = 1'b1;
      k_nxt    = '0;
      tri_nxt  = '0;
      slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      k_r        <= '0;
      tri_r      <= '0;
      slot_r     <= '0;
      v1_valid_r <= 1'b0;
      v2_valid_r <= 1'b0;
      v3_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
      tri_r  <= tri_nxt;
      slot_r <= slot_nxt;
      if (v1_en) v1_valid_r <= issue;
      if (v2_en) v2_valid_r <= v1_valid_r;
      if (v3_en) v3_valid_r <= v2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    bank_r <= bank_nxt;
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [AccW-1:0] sum;
    logic signed [SumW-1:0] moved;

    assign sum   = v1_a_r[i] + v1_b_r[i] + bxtri_pkg::RoundHalf;
    assign moved = SumW'(v2_hi_r[i]) + SumW'($signed(v2_c_r[i]));

    always_ff @(posedge clk) begin
      if (v1_en) begin
        v1_a_r[i] <= bxtri_pkg::signed_term(bank_r.term[3*i],   code[0])
                   + bxtri_pkg::signed_term(bank_r.term[3*i+1], code[1]);
        v1_b_r[i] <= bxtri_pkg::signed_term(bank_r.term[3*i+2], code[2]);
        v1_c_r[i] <= bank_r.center[i];
      end
      if (v2_en) begin
        v2_hi_r[i] <= sum[AccW-1:bxtri_pkg::FracBits];
        v2_c_r[i]  <= v1_c_r[i];
      end
      if (v3_en) begin
        // clamp when the sign bit of a 32-bit word and the bits above it disagree
        if (&moved[SumW-1:CoordW-1] || !(|moved[SumW-1:CoordW-1])) begin
          v3_vert_r[i] <= moved[CoordW-1:0];
        end else begin
          v3_vert_r[i] <= moved[SumW-1] ? {1'b1, {(CoordW-1){1'b0}}}
                                        : {1'b0, {(CoordW-1){1'b1}}};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1_en) begin
      v1_tri_r  <= tri_r;
      v1_slot_r <= slot_r;
      v1_last_r <= (k_r == bxtri_pkg::LastVert);
    end
    if (v2_en) begin
      v2_tri_r  <= v1_tri_r;
      v2_slot_r <= v1_slot_r;
      v2_last_r <= v1_last_r;
    end
    if (v3_en) begin
      v3_tri_r  <= v2_tri_r;
      v3_slot_r <= v2_slot_r;
      v3_last_r <= v2_last_r;
    end
  end

  assign out_valid          = v3_valid_r;
  assign out_vertex_x       = $signed(v3_vert_r[0]);
  assign out_vertex_y       = $signed(v3_vert_r[1]);
  assign out_vertex_z       = $signed(v3_vert_r[2]);
  assign out_triangle_index = v3_tri_r;
  assign out_corner_slot    = v3_slot_r;
  assign out_last           = v3_last_r;

`ifndef NO_ASSERTIONS
  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (k_r == '0) && (tri_r == '0) && (slot_r == '0))
    else $error("sequencer counters not cleared while idle");

  a_last_is_final_corner: assert property (@(posedge clk) disable iff (!rst_n)
    issue && (k_r == bxtri_pkg::LastVert) |->
      (tri_r == bxtri_pkg::LastTri) && (slot_r == bxtri_pkg::LastSlot))
    else $error("final vertex not at last triangle and slot");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (slot_r != 2'd3) && (k_r <= bxtri_pkg::LastVert))
    else $error("sequencer counter out of range");

  a_out_last_tags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      (out_triangle_index == bxtri_pkg::LastTri) && (out_corner_slot == bxtri_pkg::LastSlot))
    else $error("last flag on a vertex other than the final one");
`endif

endmodule

`default_nettype wire

// ----- rtl/box_to_rotated_triangles_unit.sv -----
// Top level of the box triangulator: set-up pipeline feeding the vertex pipeline.
//
// Usage: one beat on the in_ channel carries a box (Q16.16 centre, unsigned
// Q15.16 edge lengths, Q1.14 quaternion). The out_ channel then delivers 36
// beats, one vertex each: twelve triangles of three corners in the order
// abc, acd, abf, afe, bcg, bgf, dcg, dgh, adh, ahe, efg, egh, tagged with
// triangle index, corner slot and a last flag on the 36th beat.
// The first vertex of a box passes the four set-up stages, the vertex bank
// and the three vertex stages. The vertex sequencer walks the corner table,
// one vertex per cycle while the receiver does not stall. The set-up pipeline
// takes the next boxes meanwhile, so the following box starts with no gap.
// Reset clears all valid bits and the sequencer; nothing else needs clearing.
// When the receiver stalls, every stage holds its beat and the input side
// keeps filling until the set-up stages are full, then drops in_ready.
`default_nettype none

module box_to_rotated_triangles_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [bxtri_pkg::CoordW-1:0]   in_center_x,
  input  wire logic signed [bxtri_pkg::CoordW-1:0]   in_center_y,
  input  wire logic signed [bxtri_pkg::CoordW-1:0]   in_center_z,
  input  wire logic        [bxtri_pkg::LenW-1:0]     in_length_x,
  input  wire logic        [bxtri_pkg::LenW-1:0]     in_length_y,
  input  wire logic        [bxtri_pkg::LenW-1:0]     in_length_z,
  input  wire logic signed [bxtri_pkg::QuatW-1:0]    in_quat_w,
  input  wire logic signed [bxtri_pkg::QuatW-1:0]    in_quat_x,
  input  wire logic signed [bxtri_pkg::QuatW-1:0]    in_quat_y,
  input  wire logic signed [bxtri_pkg::QuatW-1:0]    in_quat_z,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [bxtri_pkg::CoordW-1:0]        out_vertex_x,
  output logic signed [bxtri_pkg::CoordW-1:0]        out_vertex_y,
  output logic signed [bxtri_pkg::CoordW-1:0]        out_vertex_z,
  output logic        [3:0]                          out_triangle_index,
  output logic        [1:0]                          out_corner_slot,
  output logic                                       out_last
);

  // hand-over between the per-box set-up and the per-vertex sequencer
  logic                set_valid;
  logic                set_ready;
  bxtri_pkg::box_set_t set_data;

  bxtri_setup u_setup (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_center_z (in_center_z),
    .in_length_x (in_length_x),
    .in_length_y (in_length_y),
    .in_length_z (in_length_z),
    .in_quat_w   (in_quat_w),
    .in_quat_x   (in_quat_x),
    .in_quat_y   (in_quat_y),
    .in_quat_z   (in_quat_z),
    .set_valid   (set_valid),
    .set_ready   (set_ready),
    .set_data    (set_data)
  );

  // walk the 36 corners, sum signed terms, round, add the centre, saturate
  bxtri_vertex u_vertex (
    .clk                (clk),
    .rst_n              (rst_n),
    .set_valid          (set_valid),
    .set_ready          (set_ready),
    .set_data           (set_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_vertex_x       (out_vertex_x),
    .out_vertex_y       (out_vertex_y),
    .out_vertex_z       (out_vertex_z),
    .out_triangle_index (out_triangle_index),
    .out_corner_slot    (out_corner_slot),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire
